@@ rtl/cpl_pkg.sv @@
// Shared constants and types for the chat message line parser.
// No dependencies; the interfaces and the top level use it.
package cpl_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PartW = 4;
  localparam int unsigned ErrW  = 4;

  // Part codes of a result word
  localparam logic [PartW-1:0] PART_SKIP   = 4'd0;
  localparam logic [PartW-1:0] PART_KEY    = 4'd1;
  localparam logic [PartW-1:0] PART_VALUE  = 4'd2;
  localparam logic [PartW-1:0] PART_PREFIX = 4'd3;
  localparam logic [PartW-1:0] PART_USER   = 4'd4;
  localparam logic [PartW-1:0] PART_HOST   = 4'd5;
  localparam logic [PartW-1:0] PART_CMD    = 4'd6;
  localparam logic [PartW-1:0] PART_MIDDLE = 4'd7;
  localparam logic [PartW-1:0] PART_TRAIL  = 4'd8;

  // Error codes
  localparam logic [ErrW-1:0] ERR_NONE      = 4'd0;
  localparam logic [ErrW-1:0] ERR_EARLY_END = 4'd1;
  localparam logic [ErrW-1:0] ERR_BAD_KEY   = 4'd2;
  localparam logic [ErrW-1:0] ERR_BAD_ESC   = 4'd3;
  localparam logic [ErrW-1:0] ERR_TAGS_END  = 4'd4;
  localparam logic [ErrW-1:0] ERR_BAD_CMD   = 4'd5;
  localparam logic [ErrW-1:0] ERR_EMPTY_MID = 4'd6;
  localparam logic [ErrW-1:0] ERR_EMPTY_UH  = 4'd7;
  localparam logic [ErrW-1:0] ERR_NO_CR     = 4'd8;
  localparam logic [ErrW-1:0] ERR_NO_LF     = 4'd9;
  localparam logic [ErrW-1:0] ERR_EXTRA     = 4'd10;

  // Characters
  localparam logic [ByteW-1:0] CH_AT    = 8'h40;  // '@'
  localparam logic [ByteW-1:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [ByteW-1:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [ByteW-1:0] CH_BANG  = 8'h21;  // '!'
  localparam logic [ByteW-1:0] CH_BSL   = 8'h5C;  // backslash
  localparam logic [ByteW-1:0] CH_LC_S  = 8'h73;  // 's'
  localparam logic [ByteW-1:0] CH_LC_R  = 8'h72;  // 'r'
  localparam logic [ByteW-1:0] CH_LC_N  = 8'h6E;  // 'n'
  localparam logic [ByteW-1:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
  localparam logic [ByteW-1:0] CH_NUL   = 8'h00;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_DASH  = 8'h2D;
  localparam logic [ByteW-1:0] CH_SLASH = 8'h2F;
  localparam logic [ByteW-1:0] CH_PLUS  = 8'h2B;

  typedef enum logic [18:0] {
    PH_START  = 19'd1,
    PH_KEY    = 19'd2,
    PH_VALUE  = 19'd4,
    PH_TAGSP  = 19'd8,
    PH_PFXCHK = 19'd16,
    PH_MAIN   = 19'd32,
    PH_USER   = 19'd64,
    PH_HOST   = 19'd128,
    PH_PFXSP  = 19'd256,
    PH_CMD1   = 19'd512,
    PH_CMDA   = 19'd1024,
    PH_CMDD   = 19'd2048,
    PH_PARAMS = 19'd4096,
    PH_PSP    = 19'd8192,
    PH_MIDDLE = 19'd16384,
    PH_TRAIL  = 19'd32768,
    PH_CR     = 19'd65536,
    PH_LF     = 19'd131072,
    PH_END    = 19'd262144
  } phase_t;

endpackage

@@ rtl/cpl_if.sv @@
// Valid/ready channel interfaces of the chat message line parser.
// Depends on cpl_pkg for field widths.
interface cpl_in_if;
  logic                      valid;
  logic                      ready;
  logic [cpl_pkg::ByteW-1:0] byte_in;
  logic                      last_byte;

  modport source (output valid, byte_in, last_byte, input ready);
  modport sink   (input valid, byte_in, last_byte, output ready);
endinterface

interface cpl_out_if;
  logic                      valid;
  logic                      ready;
  logic [cpl_pkg::PartW-1:0] part;
  logic [cpl_pkg::ByteW-1:0] char_out;
  logic                      char_valid;
  logic                      field_start;
  logic                      message_done;
  logic [cpl_pkg::ErrW-1:0]  error_code;

  modport source (output valid, part, char_out, char_valid, field_start, message_done,
                  error_code, input ready);
  modport sink   (input valid, part, char_out, char_valid, field_start, message_done,
                  error_code, output ready);
endinterface

interface cpl_cfg_if;
  logic valid;
  logic ready;
  logic expect_crlf;

  modport source (output valid, expect_crlf, input ready);
  modport sink   (input valid, expect_crlf, output ready);
endinterface

@@ rtl/chat_message_line_parser.sv @@
// Chat message line parser top level: per-byte classifier with tag unescape.
// Depends on cpl_pkg and the channel interfaces in cpl_if.sv.
// The result word of an accepted input byte is held in the output register from the next cycle.
// Throughput: one byte per cycle; the parse state updates in the accept cycle, so the
//   output register is the only stage and input ready drops only while a result is stalled.
// Reset (rst_n, synchronous, active low): parser at start of message, no error,
//   expect_crlf = 1, output register empty.
module chat_message_line_parser (
  input  logic      clk,
  input  logic      rst_n,
  cpl_in_if.sink    in_if,
  cpl_out_if.source out_if,
  cpl_cfg_if.sink   cfg_if
);

  // Working context threaded through the phase steps of one byte.
  typedef struct packed {
    cpl_pkg::phase_t             phase;
    logic                        esc;
    logic [1:0]                  dcnt;
    logic                        fempty;
    logic [cpl_pkg::PartW-1:0]   part;
    logic [cpl_pkg::ByteW-1:0]   ch;
    logic                        valid;
    logic                        fs;
    logic [cpl_pkg::ErrW-1:0]    err;
    logic                        done;
  } ctx_t;

  // A byte can fall through at most three phases (such as middle, params, CR check).
  localparam int unsigned MaxHops = 4;

  function automatic logic is_alpha(logic [cpl_pkg::ByteW-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(logic [cpl_pkg::ByteW-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_keych(logic [cpl_pkg::ByteW-1:0] c);
    return is_alpha(c) || is_digit(c) || c == cpl_pkg::CH_DASH ||
           c == cpl_pkg::CH_SLASH || c == cpl_pkg::CH_PLUS;
  endfunction

  function automatic logic is_eol(logic [cpl_pkg::ByteW-1:0] c);
    return c == cpl_pkg::CH_CR || c == cpl_pkg::CH_LF || c == cpl_pkg::CH_NUL;
  endfunction

  // One phase of the parser; clears done when the byte must be looked at again.
  function automatic ctx_t parse_step(ctx_t cur, logic [cpl_pkg::ByteW-1:0] c, logic crlf);
    ctx_t n;
    n      = cur;
    n.done = 1'b1;
    unique case (cur.phase)
      cpl_pkg::PH_START: begin
        if (c == cpl_pkg::CH_AT) begin
          n.phase = cpl_pkg::PH_KEY; n.fempty = 1'b1; n.fs = 1'b1;
        end else begin
          n.phase = cpl_pkg::PH_PFXCHK; n.done = 1'b0;
        end
      end
      cpl_pkg::PH_KEY: begin
        priority if (is_keych(c)) begin
          n.part = cpl_pkg::PART_KEY; n.ch = c; n.valid = 1'b1; n.fempty = 1'b0;
        end else if (cur.fempty) begin
          n.err = cpl_pkg::ERR_BAD_KEY;
        end else if (c == cpl_pkg::CH_EQ) begin
          n.phase = cpl_pkg::PH_VALUE; n.esc = 1'b0; n.fs = 1'b1;
        end else if (c == cpl_pkg::CH_SEMI) begin
          n.fempty = 1'b1; n.fs = 1'b1;
        end else if (c == cpl_pkg::CH_SPACE) begin
          n.phase = cpl_pkg::PH_TAGSP;
        end else begin
          n.err = cpl_pkg::ERR_TAGS_END;
        end
      end
      cpl_pkg::PH_VALUE: begin
        if (cur.esc) begin
          // decode the escaped byte
          priority if (c == cpl_pkg::CH_COLON) n.ch = cpl_pkg::CH_SEMI;
          else if (c == cpl_pkg::CH_LC_S)      n.ch = cpl_pkg::CH_SPACE;
          else if (c == cpl_pkg::CH_BSL)       n.ch = cpl_pkg::CH_BSL;
          else if (c == cpl_pkg::CH_LC_R)      n.ch = cpl_pkg::CH_CR;
          else if (c == cpl_pkg::CH_LC_N)      n.ch = cpl_pkg::CH_LF;
          else                                 n.err = cpl_pkg::ERR_BAD_ESC;
          if (n.err == cpl_pkg::ERR_NONE) begin
            n.esc = 1'b0; n.part = cpl_pkg::PART_VALUE; n.valid = 1'b1;
          end
        end else begin
          priority if (c == cpl_pkg::CH_SEMI) begin
            n.phase = cpl_pkg::PH_KEY; n.fempty = 1'b1; n.fs = 1'b1;
          end else if (c == cpl_pkg::CH_SPACE) begin
            n.phase = cpl_pkg::PH_TAGSP;
          end else if (is_eol(c)) begin
            n.err = cpl_pkg::ERR_TAGS_END;
          end else if (c == cpl_pkg::CH_BSL) begin
            n.esc = 1'b1; n.part = cpl_pkg::PART_VALUE;
          end else begin
            n.part = cpl_pkg::PART_VALUE; n.ch = c; n.valid = 1'b1;
          end
        end
      end
      cpl_pkg::PH_TAGSP: begin
        if (c != cpl_pkg::CH_SPACE) begin
          n.phase = cpl_pkg::PH_PFXCHK; n.done = 1'b0;
        end
      end
      cpl_pkg::PH_PFXCHK: begin
        if (c == cpl_pkg::CH_COLON) begin
          n.phase = cpl_pkg::PH_MAIN; n.fs = 1'b1;
        end else begin
          n.phase = cpl_pkg::PH_CMD1; n.done = 1'b0;
        end
      end
      cpl_pkg::PH_MAIN: begin
        priority if (c == cpl_pkg::CH_SPACE) begin
          n.phase = cpl_pkg::PH_PFXSP;
        end else if (c == cpl_pkg::CH_BANG) begin
          n.phase = cpl_pkg::PH_USER; n.fempty = 1'b1; n.fs = 1'b1;
        end else if (c == cpl_pkg::CH_AT) begin
          n.phase = cpl_pkg::PH_HOST; n.fempty = 1'b1; n.fs = 1'b1;
        end else begin
          n.part = cpl_pkg::PART_PREFIX; n.ch = c; n.valid = 1'b1;
        end
      end
      cpl_pkg::PH_USER: begin
        if (c == cpl_pkg::CH_SPACE || c == cpl_pkg::CH_AT) begin
          priority if (cur.fempty) begin
            n.err = cpl_pkg::ERR_EMPTY_UH;
          end else if (c == cpl_pkg::CH_SPACE) begin
            n.phase = cpl_pkg::PH_PFXSP;
          end else begin
            n.phase = cpl_pkg::PH_HOST; n.fempty = 1'b1; n.fs = 1'b1;
          end
        end else begin
          n.part = cpl_pkg::PART_USER; n.ch = c; n.valid = 1'b1; n.fempty = 1'b0;
        end
      end
      cpl_pkg::PH_HOST: begin
        if (c == cpl_pkg::CH_SPACE) begin
          if (cur.fempty) n.err = cpl_pkg::ERR_EMPTY_UH;
          else            n.phase = cpl_pkg::PH_PFXSP;
        end else begin
          n.part = cpl_pkg::PART_HOST; n.ch = c; n.valid = 1'b1; n.fempty = 1'b0;
        end
      end
      cpl_pkg::PH_PFXSP: begin
        if (c != cpl_pkg::CH_SPACE) begin
          n.phase = cpl_pkg::PH_CMD1; n.done = 1'b0;
        end
      end
      cpl_pkg::PH_CMD1: begin
        priority if (is_alpha(c)) begin
          n.phase = cpl_pkg::PH_CMDA; n.part = cpl_pkg::PART_CMD; n.ch = c; n.valid = 1'b1;
        end else if (is_digit(c)) begin
          n.phase = cpl_pkg::PH_CMDD; n.dcnt = 2'd1;
          n.part  = cpl_pkg::PART_CMD; n.ch = c; n.valid = 1'b1;
        end else begin
          n.err = cpl_pkg::ERR_BAD_CMD;
        end
      end
      cpl_pkg::PH_CMDA: begin
        if (is_alpha(c)) begin
          n.part = cpl_pkg::PART_CMD; n.ch = c; n.valid = 1'b1;
        end else begin
          n.phase = cpl_pkg::PH_PARAMS; n.done = 1'b0;
        end
      end
      cpl_pkg::PH_CMDD: begin
        if (is_digit(c)) begin
          n.part = cpl_pkg::PART_CMD; n.ch = c; n.valid = 1'b1;
          n.dcnt = cur.dcnt + 2'd1;
          if (n.dcnt == 2'd3) n.phase = cpl_pkg::PH_PARAMS;
        end else begin
          n.err = cpl_pkg::ERR_BAD_CMD;
        end
      end
      cpl_pkg::PH_PARAMS: begin
        if (c == cpl_pkg::CH_SPACE) begin
          n.phase = cpl_pkg::PH_PSP;
        end else begin
          n.phase = crlf ? cpl_pkg::PH_CR : cpl_pkg::PH_END; n.done = 1'b0;
        end
      end
      cpl_pkg::PH_PSP: begin
        priority if (c == cpl_pkg::CH_SPACE) begin
          n.done = 1'b1;
        end else if (c == cpl_pkg::CH_COLON) begin
          n.phase = cpl_pkg::PH_TRAIL; n.fs = 1'b1;
        end else begin
          n.phase = cpl_pkg::PH_MIDDLE; n.fempty = 1'b1; n.done = 1'b0;
        end
      end
      cpl_pkg::PH_MIDDLE: begin
        if (c == cpl_pkg::CH_SPACE || is_eol(c)) begin
          if (cur.fempty) begin
            n.err = cpl_pkg::ERR_EMPTY_MID;
          end else begin
            n.phase = cpl_pkg::PH_PARAMS; n.done = 1'b0;
          end
        end else begin
          n.part = cpl_pkg::PART_MIDDLE; n.ch = c; n.valid = 1'b1;
          n.fs   = cur.fempty; n.fempty = 1'b0;
        end
      end
      cpl_pkg::PH_TRAIL: begin
        if (is_eol(c)) begin
          n.phase = crlf ? cpl_pkg::PH_CR : cpl_pkg::PH_END; n.done = 1'b0;
        end else begin
          n.part = cpl_pkg::PART_TRAIL; n.ch = c; n.valid = 1'b1;
        end
      end
      cpl_pkg::PH_CR: begin
        if (c == cpl_pkg::CH_CR) n.phase = cpl_pkg::PH_LF;
        else                     n.err = cpl_pkg::ERR_NO_CR;
      end
      cpl_pkg::PH_LF: begin
        if (c == cpl_pkg::CH_LF) n.phase = cpl_pkg::PH_END;
        else                     n.err = cpl_pkg::ERR_NO_LF;
      end
      default: begin
        // line already complete
        n.err = cpl_pkg::ERR_EXTRA;
      end
    endcase
    return n;
  endfunction

  // Status given on the last byte when no error was raised.
  function automatic logic [cpl_pkg::ErrW-1:0] end_status(cpl_pkg::phase_t ph, logic crlf);
    logic [cpl_pkg::ErrW-1:0] st;
    st = cpl_pkg::ERR_EARLY_END;
    if (ph == cpl_pkg::PH_CMDA || ph == cpl_pkg::PH_PARAMS || ph == cpl_pkg::PH_PSP ||
        ph == cpl_pkg::PH_MIDDLE || ph == cpl_pkg::PH_TRAIL) begin
      st = crlf ? cpl_pkg::ERR_EARLY_END : cpl_pkg::ERR_NONE;
    end else if (ph == cpl_pkg::PH_END) begin
      st = cpl_pkg::ERR_NONE;
    end
    return st;
  endfunction

  // Parse state
  cpl_pkg::phase_t           phase_r,  phase_nxt;
  logic                      esc_r,    esc_nxt;
  logic [1:0]                dcnt_r,   dcnt_nxt;
  logic                      fempty_r, fempty_nxt;
  logic [cpl_pkg::ErrW-1:0]  err_r,    err_nxt;
  logic                      crlf_r;

  // Output register
  logic                      out_vld_r;
  logic [cpl_pkg::PartW-1:0] part_r,  part_nxt;
  logic [cpl_pkg::ByteW-1:0] ch_r,    ch_nxt;
  logic                      cval_r,  cval_nxt;
  logic                      fs_r,    fs_nxt;
  logic                      done_r;
  logic [cpl_pkg::ErrW-1:0]  code_r,  code_nxt;

  logic in_acc;
  ctx_t ctx [MaxHops+1];

  // Take a new byte whenever the output register is free or being drained.
  assign in_if.ready  = !out_vld_r || out_if.ready;
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  always_comb begin
    ctx[0]        = '0;
    ctx[0].phase  = phase_r;
    ctx[0].esc    = esc_r;
    ctx[0].dcnt   = dcnt_r;
    ctx[0].fempty = fempty_r;
    ctx[0].part   = cpl_pkg::PART_SKIP;
    ctx[0].err    = cpl_pkg::ERR_NONE;
    for (int i = 0; i < MaxHops; i++) begin
      if (ctx[i].done) ctx[i+1] = ctx[i];
      else             ctx[i+1] = parse_step(ctx[i], in_if.byte_in, crlf_r);
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    esc_nxt    = esc_r;
    dcnt_nxt   = dcnt_r;
    fempty_nxt = fempty_r;
    part_nxt   = cpl_pkg::PART_SKIP;
    ch_nxt     = '0;
    cval_nxt   = 1'b0;
    fs_nxt     = 1'b0;
    code_nxt   = err_r;
    // Once an error is latched, ignore bytes until the last one.
    if (err_r == cpl_pkg::ERR_NONE) begin
      phase_nxt  = ctx[MaxHops].phase;
      esc_nxt    = ctx[MaxHops].esc;
      dcnt_nxt   = ctx[MaxHops].dcnt;
      fempty_nxt = ctx[MaxHops].fempty;
      if (ctx[MaxHops].err != cpl_pkg::ERR_NONE) begin
        code_nxt = ctx[MaxHops].err;
      end else begin
        part_nxt = ctx[MaxHops].part;
        ch_nxt   = ctx[MaxHops].valid ? ctx[MaxHops].ch : '0;
        cval_nxt = ctx[MaxHops].valid;
        fs_nxt   = ctx[MaxHops].fs;
        if (in_if.last_byte) code_nxt = end_status(ctx[MaxHops].phase, crlf_r);
      end
    end
    err_nxt = code_nxt;
    // Return to start of message after the final byte.
    if (in_if.last_byte) begin
      phase_nxt  = cpl_pkg::PH_START;
      esc_nxt    = 1'b0;
      dcnt_nxt   = 2'd0;
      fempty_nxt = 1'b1;
      err_nxt    = cpl_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= cpl_pkg::PH_START;
      esc_r     <= 1'b0;
      dcnt_r    <= 2'd0;
      fempty_r  <= 1'b1;
      err_r     <= cpl_pkg::ERR_NONE;
      crlf_r    <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_if.valid) crlf_r <= cfg_if.expect_crlf;
      if (in_acc) begin
        phase_r  <= phase_nxt;
        esc_r    <= esc_nxt;
        dcnt_r   <= dcnt_nxt;
        fempty_r <= fempty_nxt;
        err_r    <= err_nxt;
      end
      if (in_acc)            out_vld_r <= 1'b1;
      else if (out_if.ready) out_vld_r <= 1'b0;
    end
  end

  // Payload: load with each accepted byte, hold while stalled.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      part_r <= part_nxt;
      ch_r   <= ch_nxt;
      cval_r <= cval_nxt;
      fs_r   <= fs_nxt;
      done_r <= in_if.last_byte;
      code_r <= code_nxt;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.part         = part_r;
  assign out_if.char_out     = ch_r;
  assign out_if.char_valid   = cval_r;
  assign out_if.field_start  = fs_r;
  assign out_if.message_done = done_r;
  assign out_if.error_code   = code_r;

  // A final byte always leaves the parser at start of message with no error.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_if.last_byte |=> phase_r == cpl_pkg::PH_START && err_r == cpl_pkg::ERR_NONE)
    else $error("parser state not cleared after last byte");

  // An escape can only be pending inside a tag value.
  a_esc_in_value: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> phase_r == cpl_pkg::PH_VALUE)
    else $error("escape pending outside tag value");

  // With the output register empty, input must be taken.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_if.ready)
    else $error("input stalled with empty output register");

  // A byte that carries content is never a skip or an error byte.
  a_content_part: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && cval_nxt |-> part_nxt != cpl_pkg::PART_SKIP &&
    (err_r == cpl_pkg::ERR_NONE))
    else $error("content byte without a part");

endmodule
